// File: rtl/g2dc_pkg.sv
package g2dc_pkg;

    localparam int WIN        = 5;
    localparam int HALF       = 2;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 12;
    localparam int HIST_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_WID_W  = 11;
    localparam int HEIGHT_W   = 16;
    localparam int PROD_W     = COEF_W + PIX_W + 1;
    localparam int ROW_SUM_W  = PROD_W + 3;
    localparam int SUM_W      = ROW_SUM_W + 3;
    localparam int FRAC_W     = 4;

    localparam logic [PIX_W-1:0]      PIX_MAX         = 8'd255;
    localparam logic [CFG_WID_W-1:0]  WIDTH_RESET     = 11'd1024;
    localparam logic [HEIGHT_W-1:0]   HEIGHT_RESET    = 16'd1;
    localparam logic [CFG_DATA_W-1:0] COEF_ROW2_RESET = 60'h000_0000_1000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEF_ROW0    = 3'd2,
        CFG_COEF_ROW1    = 3'd3,
        CFG_COEF_ROW2    = 3'd4,
        CFG_COEF_ROW3    = 3'd5,
        CFG_COEF_ROW4    = 3'd6
    } t_cfg_reg;

    typedef logic [WIN-1:0][PIX_W-1:0] t_pix_col;

endpackage

// File: rtl/g2dc_ram.sv
module g2dc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/grayscale_2d_convolution_core.sv
// 5x5 zero-padded convolution over an 8-bit grayscale raster stream. One word is
// taken per clock while o_ready is high; a result word moves through the line store,
// padding, product, row-sum and output registers after the word completing its window is
// accepted, and the result of pixel k is caused by input word k + 2*width + 2, so
// 2*width + 2 flush words drain a frame. The rate is set by the line store: one read
// and one write of its column entry per word, on separate read and write ports, with
// the last write forwarded when consecutive words hit the same column. A waiting result
// stalls the whole pipeline, so o_ready follows i_ready while o_valid is high. After
// reset and after each configuration write, o_ready is low in the following clock while
// the position counters are rebuilt from row and column with the width multiply.
module grayscale_2d_convolution_core #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int KERNEL_SIZE    = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_mode,
    input  logic [g2dc_pkg::PIX_W-1:0]           i_pixel_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [g2dc_pkg::PIX_W-1:0]           o_result_pixel,
    output logic                                 o_last_of_frame,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [g2dc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [g2dc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW  = $clog2(MAX_LINE_WIDTH);
    localparam int WW  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int RW  = g2dc_pkg::HEIGHT_W + 1;
    localparam int LW  = WW + RW + 1;
    localparam int KLO = g2dc_pkg::HALF - KERNEL_SIZE / 2;
    localparam int KHI = KLO + KERNEL_SIZE - 1;

    localparam int WIN   = g2dc_pkg::WIN;
    localparam int PIX_W = g2dc_pkg::PIX_W;

    // configuration
    logic [g2dc_pkg::CFG_WID_W-1:0]  r_image_width;
    logic [g2dc_pkg::HEIGHT_W-1:0]   r_image_height;
    logic [g2dc_pkg::CFG_DATA_W-1:0] r_coef [WIN];
    logic                            r_busy;
    logic [WW-1:0]                   eff_w;
    logic [g2dc_pkg::HEIGHT_W-1:0]   eff_h;

    // positions
    logic [CW-1:0]                 r_in_col, n_in_col;
    logic [RW-1:0]                 r_in_row, n_in_row;
    logic [CW-1:0]                 r_out_col, n_out_col;
    logic [g2dc_pkg::HEIGHT_W-1:0] r_out_row, n_out_row;
    logic [LW-1:0]                 r_in_lin, n_in_lin;
    logic [LW-1:0]                 r_out_lin, n_out_lin;
    logic [LW-1:0]                 r_total;
    logic [LW-1:0]                 r_thresh;

    logic             en;
    logic             acc;
    logic             in_range;
    logic             ignore;
    logic             emit;
    logic             last;
    logic [WIN-1:0]   row_ok;
    logic [WIN-1:0]   col_ok;
    logic [PIX_W-1:0] wr_pix;

    // stage 1: line store access
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic [WIN-1:0]   r_s1_row_ok;
    logic [WIN-1:0]   r_s1_col_ok;

    logic [g2dc_pkg::HIST_W-1:0] ram_rdata;
    logic [g2dc_pkg::HIST_W-1:0] hist;
    logic [g2dc_pkg::HIST_W-1:0] ram_wdata;
    logic                        ram_we;
    logic                        r_fw_valid;
    logic [CW-1:0]               r_fw_addr;
    logic [g2dc_pkg::HIST_W-1:0] r_fw_data;

    g2dc_pkg::t_pix_col new_col;
    g2dc_pkg::t_pix_col r_win [WIN];
    g2dc_pkg::t_pix_col n_win [WIN];

    // stages 2..4
    logic               r_s2_valid;
    logic               r_s2_last;
    g2dc_pkg::t_pix_col r_s2_pix [WIN];

    logic                                 r_s3_valid;
    logic                                 r_s3_last;
    logic signed [g2dc_pkg::PROD_W-1:0]   r_s3_prod [WIN][WIN];

    logic                                  r_s4_valid;
    logic                                  r_s4_last;
    logic signed [g2dc_pkg::ROW_SUM_W-1:0] r_s4_row [WIN];
    logic signed [g2dc_pkg::ROW_SUM_W-1:0] row_sum [WIN];
    logic signed [g2dc_pkg::SUM_W-1:0]     total_sum;
    logic [PIX_W-1:0]                      clamped;

    logic             r_o_valid;
    logic             r_o_last;
    logic [PIX_W-1:0] r_o_pixel;

    // effective sizes
    always_comb begin
        if (r_image_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_image_width) > MAX_LINE_WIDTH) begin
            eff_w = WW'(MAX_LINE_WIDTH);
        end else begin
            eff_w = WW'(r_image_width);
        end
        eff_h = (r_image_height == '0) ? g2dc_pkg::HEIGHT_W'(1) : r_image_height;
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= g2dc_pkg::WIDTH_RESET;
            r_image_height <= g2dc_pkg::HEIGHT_RESET;
            for (int r = 0; r < WIN; r++) begin
                r_coef[r] <= '0;
            end
            r_coef[2] <= g2dc_pkg::COEF_ROW2_RESET;
            r_busy    <= 1'b1;
        end else begin
            r_busy <= i_cfg_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    g2dc_pkg::CFG_IMAGE_WIDTH: begin
                        r_image_width <= i_cfg_data[g2dc_pkg::CFG_WID_W-1:0];
                    end
                    g2dc_pkg::CFG_IMAGE_HEIGHT: begin
                        r_image_height <= i_cfg_data[g2dc_pkg::HEIGHT_W-1:0];
                    end
                    g2dc_pkg::CFG_COEF_ROW0: r_coef[0] <= i_cfg_data;
                    g2dc_pkg::CFG_COEF_ROW1: r_coef[1] <= i_cfg_data;
                    g2dc_pkg::CFG_COEF_ROW2: r_coef[2] <= i_cfg_data;
                    g2dc_pkg::CFG_COEF_ROW3: r_coef[3] <= i_cfg_data;
                    g2dc_pkg::CFG_COEF_ROW4: r_coef[4] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // input side
    assign en      = !r_o_valid || i_ready;
    assign o_ready = en && !r_busy;
    assign acc     = i_valid && o_ready;

    always_comb begin
        in_range = r_in_lin < r_total;
        ignore   = in_range && i_mode;
        emit     = r_in_lin >= r_out_lin + r_thresh;
        last     = (r_out_lin + LW'(1)) >= r_total;
        wr_pix   = (in_range && !i_mode) ? i_pixel_value : '0;

        row_ok[0] = RW'(r_out_row) >= RW'(2);
        row_ok[1] = RW'(r_out_row) >= RW'(1);
        row_ok[2] = 1'b1;
        row_ok[3] = RW'(r_out_row) + RW'(1) < RW'(eff_h);
        row_ok[4] = RW'(r_out_row) + RW'(2) < RW'(eff_h);

        col_ok[0] = (WW + 1)'(r_out_col) >= (WW + 1)'(2);
        col_ok[1] = (WW + 1)'(r_out_col) >= (WW + 1)'(1);
        col_ok[2] = 1'b1;
        col_ok[3] = (WW + 1)'(r_out_col) + (WW + 1)'(1) < (WW + 1)'(eff_w);
        col_ok[4] = (WW + 1)'(r_out_col) + (WW + 1)'(2) < (WW + 1)'(eff_w);

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_lin  = r_in_lin;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_out_lin = r_out_lin;
        if (acc && !ignore) begin
            n_in_lin = r_in_lin + LW'(1);
            if (WW'(r_in_col) + WW'(1) >= eff_w) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_in_lin  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_out_lin = '0;
                end else begin
                    n_out_lin = r_out_lin + LW'(1);
                    if (WW'(r_out_col) + WW'(1) >= eff_w) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + g2dc_pkg::HEIGHT_W'(1);
                    end else begin
                        n_out_col = r_out_col + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_lin  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_lin <= '0;
            r_total   <= '0;
            r_thresh  <= '0;
        end else if (r_busy) begin
            r_total   <= LW'(eff_w) * LW'(eff_h);
            r_thresh  <= (LW'(eff_w) << 1) + LW'(2);
            r_in_lin  <= LW'(r_in_row) * LW'(eff_w) + LW'(r_in_col);
            r_out_lin <= LW'(r_out_row) * LW'(eff_w) + LW'(r_out_col);
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_lin  <= n_in_lin;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_out_lin <= n_out_lin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= acc && !ignore;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pix    <= wr_pix;
            r_s1_col    <= r_in_col;
            r_s1_emit   <= emit;
            r_s1_last   <= last;
            r_s1_row_ok <= row_ok;
            r_s1_col_ok <= col_ok;
        end
    end

    // line store: one entry per column, four older rows packed newest lowest
    g2dc_ram #(
        .WIDTH (g2dc_pkg::HIST_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_col),
        .i_wdata (ram_wdata),
        .i_re    (en),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        hist      = (r_fw_valid && r_fw_addr == r_s1_col) ? r_fw_data : ram_rdata;
        ram_wdata = {hist[23:0], r_s1_pix};
        ram_we    = en && r_s1_valid;
        new_col[4] = r_s1_pix;
        new_col[3] = hist[7:0];
        new_col[2] = hist[15:8];
        new_col[1] = hist[23:16];
        new_col[0] = hist[31:24];
        for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN - 1; c++) begin
                n_win[r][c] = r_win[r][c+1];
            end
            n_win[r][WIN-1] = new_col[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
            for (int r = 0; r < WIN; r++) begin
                r_win[r] <= '0;
            end
        end else if (ram_we) begin
            r_fw_valid <= 1'b1;
            r_win      <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_fw_addr <= r_s1_col;
            r_fw_data <= ram_wdata;
        end
    end

    // stage 2: zero padding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_o_valid  <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_last <= r_s1_last;
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN; c++) begin
                    r_s2_pix[r][c] <= (r_s1_row_ok[r] && r_s1_col_ok[c]) ? n_win[r][c] : '0;
                end
            end
        end
    end

    // stage 3: products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_last <= r_s2_last;
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN; c++) begin
                    if (r >= KLO && r <= KHI && c >= KLO && c <= KHI) begin
                        r_s3_prod[r][c] <=
                            g2dc_pkg::PROD_W'($signed(r_coef[r][12*c +: g2dc_pkg::COEF_W]))
                            * g2dc_pkg::PROD_W'($signed({1'b0, r_s2_pix[r][c]}));
                    end else begin
                        r_s3_prod[r][c] <= '0;
                    end
                end
            end
        end
    end

    // stage 4: row sums
    always_comb begin
        for (int r = 0; r < WIN; r++) begin
            row_sum[r] = '0;
            for (int c = 0; c < WIN; c++) begin
                row_sum[r] = row_sum[r] + g2dc_pkg::ROW_SUM_W'(r_s3_prod[r][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_last <= r_s3_last;
            r_s4_row  <= row_sum;
        end
    end

    // stage 5: total, drop fraction, clamp
    always_comb begin
        total_sum = '0;
        for (int r = 0; r < WIN; r++) begin
            total_sum = total_sum + g2dc_pkg::SUM_W'(r_s4_row[r]);
        end
        if (total_sum[g2dc_pkg::SUM_W-1]) begin
            clamped = '0;
        end else if (total_sum[g2dc_pkg::SUM_W-2:g2dc_pkg::FRAC_W] >
                     (g2dc_pkg::SUM_W - 1 - g2dc_pkg::FRAC_W)'(g2dc_pkg::PIX_MAX)) begin
            clamped = g2dc_pkg::PIX_MAX;
        end else begin
            clamped = total_sum[g2dc_pkg::FRAC_W +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_last  <= r_s4_last;
            r_o_pixel <= clamped;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_result_pixel  = r_o_pixel;
    assign o_last_of_frame = r_o_last;

    a_emit_reaches_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s1_valid && r_s1_emit |=> r_s2_valid)
        else $error("emitted word lost between line store and padding stage");

    a_last_clears_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !ignore && emit && last |=> r_out_lin == '0 && r_out_col == '0)
        else $error("output position not cleared after frame end");

    a_no_emit_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && !(r_s1_valid && r_s1_emit) |=> !r_s2_valid)
        else $error("result started for a word without result");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> $stable(r_in_col) && $stable(r_out_col))
        else $error("position counters moved during recompute");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_W      = 1024;
    localparam int KSIZE      = 5;
    localparam int HIST_LEN   = 4 * MAX_W + 8;
    localparam int ITEMS      = 1700;
    localparam int WIN        = g2dc_pkg::WIN;
    localparam int HALF       = g2dc_pkg::HALF;
    localparam int PIX_W      = g2dc_pkg::PIX_W;
    localparam int COEF_W     = g2dc_pkg::COEF_W;
    localparam int FRAC_W     = g2dc_pkg::FRAC_W;
    localparam int CFG_IDX_W  = g2dc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = g2dc_pkg::CFG_DATA_W;
    localparam int CFG_WID_W  = g2dc_pkg::CFG_WID_W;
    localparam int HEIGHT_W   = g2dc_pkg::HEIGHT_W;

    class conv_scoreboard;
        byte unsigned             hist[HIST_LEN];
        logic [CFG_WID_W-1:0]     width_reg;
        logic [HEIGHT_W-1:0]      height_reg;
        logic [CFG_DATA_W-1:0]    coef_row[WIN];
        longint                   in_col, in_row, out_col, out_row;
        logic [PIX_W:0]           expected_q[$];
        int                       errors;

        function new();
            foreach (hist[i]) hist[i] = 0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            width_reg = g2dc_pkg::WIDTH_RESET;
            height_reg = g2dc_pkg::HEIGHT_RESET;
            foreach (coef_row[r]) coef_row[r] = '0;
            coef_row[HALF] = g2dc_pkg::COEF_ROW2_RESET;
            errors = 0;
        endfunction

        function longint eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function longint eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(g2dc_pkg::t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                g2dc_pkg::CFG_IMAGE_WIDTH:  width_reg = data[CFG_WID_W-1:0];
                g2dc_pkg::CFG_IMAGE_HEIGHT: height_reg = data[HEIGHT_W-1:0];
                default:                    coef_row[idx - g2dc_pkg::CFG_COEF_ROW0] = data;
            endcase
        endfunction

        // advance the convolution by one accepted word
        function void note_input(logic mode, logic [PIX_W-1:0] pix);
            longint w, h, total, in_lin, out_lin, r, c;
            int lo, hi, sum, cv;
            logic signed [COEF_W-1:0] cf;
            byte unsigned p;
            logic [PIX_W-1:0] res;
            logic eof;
            w = eff_width();
            h = eff_height();
            total = w * h;
            in_lin = in_row * w + in_col;
            lo = HALF - KSIZE / 2;
            hi = lo + KSIZE - 1;
            sum = 0;
            if (in_lin < total) begin
                if (mode) return;
                hist[in_lin % HIST_LEN] = pix;
            end
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            out_lin = out_row * w + out_col;
            if (in_lin < out_lin + 2 * w + 2) return;
            for (int di = 0; di < WIN; di++) begin
                for (int dj = 0; dj < WIN; dj++) begin
                    r = out_row + di - HALF;
                    c = out_col + dj - HALF;
                    p = 0;
                    if (r >= 0 && r < h && c >= 0 && c < w) p = hist[(r * w + c) % HIST_LEN];
                    if (di >= lo && di <= hi && dj >= lo && dj <= hi) begin
                        cf = coef_row[di][COEF_W*dj +: COEF_W];
                        cv = cf;
                        sum += cv * int'(p);
                    end
                end
            end
            if (sum < 0) res = '0;
            else if ((sum >>> FRAC_W) > 255) res = g2dc_pkg::PIX_MAX;
            else res = PIX_W'(sum >>> FRAC_W);
            eof = (out_lin + 1 >= total);
            expected_q.push_back({res, eof});
            if (eof) begin
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] pix, logic eof);
            logic [PIX_W:0] exp_word;
            if (expected_q.size() == 0) begin
                $error("unexpected result word: result_pixel %0d last_of_frame %0d", pix, eof);
                errors++;
                return;
            end
            exp_word = expected_q.pop_front();
            if (pix !== exp_word[PIX_W:1]) begin
                $error("result_pixel: expected %0d, actual %0d", exp_word[PIX_W:1], pix);
                errors++;
            end
            if (eof !== exp_word[0]) begin
                $error("last_of_frame: expected %0d, actual %0d", exp_word[0], eof);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_mode = 1'b0;
    logic [PIX_W-1:0]      i_pixel_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PIX_W-1:0]      o_result_pixel;
    logic                  o_last_of_frame;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    conv_scoreboard sb = new();
    bit  running = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  phase_left = 0;
    int  phase_kind = 0;
    int  burst_left = 0;
    int  item_count = 0;

    grayscale_2d_convolution_core uut (.*);

    always #2 i_clk = ~i_clk;

    // result side: checks words, stalls in phases, honors a long hold request
    always @(posedge i_clk) begin
        if (running && o_valid && i_ready) sb.check_result(o_result_pixel, o_last_of_frame);
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
            i_ready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_kind = $urandom_range(0, 2);
                phase_left = $urandom_range(16, 300);
            end
            phase_left--;
            case (phase_kind)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic idle(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_word(logic mode, logic [PIX_W-1:0] pix);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 8));
        end
        burst_left--;
        i_valid <= 1'b1;
        i_mode <= mode;
        i_pixel_value <= pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(mode, pix);
        item_count++;
    endtask

    task automatic drain_wait();
        idle(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_one(g2dc_pkg::t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic write_size(logic [CFG_WID_W-1:0] w, logic [HEIGHT_W-1:0] h);
        write_one(g2dc_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_one(g2dc_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_regs(logic [CFG_WID_W-1:0] w, logic [HEIGHT_W-1:0] h, int kind);
        logic [CFG_DATA_W-1:0] data;
        int sel;
        write_one(g2dc_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_one(g2dc_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        for (int i = 0; i < WIN; i++) begin
            for (int c = 0; c < WIN; c++) begin
                sel = (kind == 5) ? int'($urandom_range(0, 4)) : kind;
                case (sel)
                    0:       data[COEF_W*c +: COEF_W] = COEF_W'($urandom);
                    1:       data[COEF_W*c +: COEF_W] = COEF_W'(int'($urandom_range(0, 64)) - 32);
                    2:       data[COEF_W*c +: COEF_W] = 12'h7FF;
                    3:       data[COEF_W*c +: COEF_W] = 12'h800;
                    default: data[COEF_W*c +: COEF_W] = '0;
                endcase
            end
            write_one(g2dc_pkg::t_cfg_reg'(int'(g2dc_pkg::CFG_COEF_ROW0) + i), data);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_frame(bit hold_mid);
        longint w, h, n;
        logic [PIX_W-1:0] pix;
        w = sb.eff_width();
        h = sb.eff_height();
        n = w * h;
        for (longint k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) send_word(1'b1, PIX_W'($urandom));
            case ($urandom_range(0, 9))
                0:       pix = '0;
                1:       pix = g2dc_pkg::PIX_MAX;
                default: pix = PIX_W'($urandom);
            endcase
            if (hold_mid && k == n / 2) hold_req = 1;
            send_word(1'b0, pix);
        end
        for (longint k = 0; k < 2 * w + 2; k++) begin
            if ($urandom_range(0, 4) == 0) send_word(1'b0, PIX_W'($urandom));
            else send_word(1'b1, PIX_W'($urandom));
        end
        drain_wait();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1;
        @(posedge i_clk);
        write_size(5, 4);
        run_frame(0);

        write_regs(3, 2, 2);
        run_frame(0);
        write_regs(3, 2, 3);
        run_frame(0);
        write_regs(0, 0, 0);
        run_frame(0);
        write_regs(1, 200, 1);
        run_frame(1);
        write_regs(40, 3, 5);
        run_frame(0);

        while (item_count < ITEMS) begin
            write_regs(($urandom_range(0, 9) == 0) ? CFG_WID_W'($urandom_range(0, 40))
                                                   : CFG_WID_W'($urandom_range(1, 12)),
                       HEIGHT_W'($urandom_range(0, 6)), int'($urandom_range(0, 5)));
            run_frame($urandom_range(0, 15) == 0);
        end

        idle(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

endmodule

// File: grayscale_2d_convolution_core.f
rtl/g2dc_pkg.sv
rtl/g2dc_ram.sv
rtl/grayscale_2d_convolution_core.sv
dv/testbench.sv
